// File: hdl/tti_pkg.sv
// Shared types, constants and state encodings for the trajectory time interpolator.
// No dependencies; imported by tti_lerp, trajectory_time_interpolator and the testbench.
`timescale 1ns / 1ps

package tti_pkg;

  // Field widths
  localparam int TIME_W    = 31;
  localparam int VAL_W     = 32;
  localparam int NUM_LANES = 5;
  localparam int LANE_W    = $clog2(NUM_LANES);
  localparam int CNT_W     = 11;
  localparam int PROD_W    = 64;
  localparam int DIV_CNT_W = $clog2(PROD_W);

  // Default table depth
  localparam int MAX_SAMPLES_DEF = 1024;

  // Quotient magnitude clamp, two to the 33rd
  localparam int QCLAMP_W = 34;

  // Register indexes
  localparam logic REG_SAMPLE_COUNT = 1'b0;
  localparam logic REG_END_TIME     = 1'b1;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD_LO,
    S_RD_HI,
    S_GOT,
    S_LSTART,
    S_LWAIT,
    S_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_FIN
  } lerp_state_t;

  // Operands for one lane of interpolation
  typedef struct packed {
    logic [VAL_W-1:0]  lo;
    logic [VAL_W-1:0]  hi;
    logic [TIME_W-1:0] num_mag;
    logic              num_neg;
    logic [TIME_W-1:0] den_mag;
    logic              den_neg;
  } lerp_req_t;

endpackage

// File: hdl/tti_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tti_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/tti_lerp.sv
// One interpolation lane: registered multiply, then a bit-serial restoring divide,
// then clamp, add and saturate. Depends on tti_pkg.
`timescale 1ns / 1ps

module tti_lerp
  import tti_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  lerp_req_t        req,
  output logic             done,
  output logic [VAL_W-1:0] result
);

  lerp_state_t state_r, state_nxt;

  logic [VAL_W-1:0]     lo_r;
  logic [VAL_W:0]       dmag_r;
  logic                 neg_r;
  logic [TIME_W-1:0]    num_r;
  logic [TIME_W-1:0]    den_r;
  logic [PROD_W-1:0]    dvd_r;
  logic [TIME_W-1:0]    rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  logic signed [VAL_W:0] diff;
  logic [TIME_W:0]       rem_sh;
  logic [TIME_W:0]       rem_sub;
  logic                  ge;
  logic [QCLAMP_W-1:0]   qc;
  logic signed [VAL_W+3:0] qs;
  logic signed [VAL_W+3:0] sum;

  // Operand difference
  always_comb begin
    diff = $signed({req.hi[VAL_W-1], req.hi}) - $signed({req.lo[VAL_W-1], req.lo});
  end

  // Divide step
  always_comb begin
    rem_sh  = {rem_r, dvd_r[PROD_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  // Clamp quotient, restore sign, add and saturate
  always_comb begin
    if (dvd_r > {{(PROD_W-QCLAMP_W){1'b0}}, 1'b1, {(QCLAMP_W-1){1'b0}}}) begin
      qc = {1'b1, {(QCLAMP_W-1){1'b0}}};
    end else begin
      qc = dvd_r[QCLAMP_W-1:0];
    end
    qs  = neg_r ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    sum = $signed({{4{lo_r[VAL_W-1]}}, lo_r}) + qs;
    if (sum > $signed({4'b0000, 1'b0, {(VAL_W-1){1'b1}}})) begin
      result = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (sum < $signed({4'b1111, 1'b1, {(VAL_W-1){1'b0}}})) begin
      result = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      result = sum[VAL_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE: if (start) state_nxt = L_MUL;
      L_MUL:  state_nxt = L_DIV;
      L_DIV:  if (cnt_r == {DIV_CNT_W{1'b1}}) state_nxt = L_FIN;
      L_FIN:  state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = (state_r == L_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        if (start) begin
          lo_r   <= req.lo;
          dmag_r <= diff[VAL_W] ? (VAL_W+1)'(0) - diff : diff;
          neg_r  <= diff[VAL_W] ^ req.num_neg ^ req.den_neg;
          num_r  <= req.num_mag;
          den_r  <= req.den_mag;
        end
      end
      L_MUL: begin
        dvd_r <= dmag_r * num_r;
        rem_r <= '0;
        cnt_r <= '0;
      end
      L_DIV: begin
        rem_r <= ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
        dvd_r <= {dvd_r[PROD_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/trajectory_time_interpolator.sv
// Flow: a sample write is taken straight from idle; a query at the end or zero time reads
// its stored sample directly, else a linear time scan (n = sample count) finds the bracket
// and returns a stored sample or runs the one divide lane for each of the five fields.
// One item is in work at a time; the result register frees the input side.
// Reset: synchronous, active low; sample_count returns to 2, end_time to 0; the tables are
// not cleared and hold undefined data until written.
`timescale 1ns / 1ps

module trajectory_time_interpolator
  import tti_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [TIME_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [9:0]        in_index,
  input  logic [TIME_W-1:0] in_sample_time,
  input  logic [VAL_W-1:0]  in_sample_x,
  input  logic [VAL_W-1:0]  in_sample_y,
  input  logic [VAL_W-1:0]  in_sample_heading,
  input  logic [VAL_W-1:0]  in_sample_speed,
  input  logic [VAL_W-1:0]  in_sample_turn_rate,
  input  logic [TIME_W-1:0] in_query_time,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TIME_W-1:0] out_time,
  output logic [VAL_W-1:0]  out_x,
  output logic [VAL_W-1:0]  out_y,
  output logic [VAL_W-1:0]  out_heading,
  output logic [VAL_W-1:0]  out_speed,
  output logic [VAL_W-1:0]  out_turn_rate,
  output logic              out_degenerate
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int VW = NUM_LANES * VAL_W;

  seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  sample_count_r;
  logic [TIME_W-1:0] end_time_r;

  logic [TIME_W-1:0] t_r;
  logic [CW-1:0]     n_r;
  logic [CW-1:0]     i_r;
  logic              pend_r;
  logic [AW-1:0]     pidx_r;
  logic [AW-1:0]     lo_r;
  logic [AW-1:0]     hi_r;
  logic              direct_r;
  logic              deg_r;
  logic [TIME_W-1:0] tlo_r;
  logic [NUM_LANES-1:0][VAL_W-1:0] vlo_r;
  logic [NUM_LANES-1:0][VAL_W-1:0] vhi_r;
  logic [NUM_LANES-1:0][VAL_W-1:0] res_r;
  logic [TIME_W-1:0] num_mag_r;
  logic              num_neg_r;
  logic [TIME_W-1:0] den_mag_r;
  logic              den_neg_r;
  logic [LANE_W-1:0] lane_r;

  logic              out_valid_r;
  logic [TIME_W-1:0] out_time_r;
  logic [NUM_LANES-1:0][VAL_W-1:0] out_vals_r;
  logic              out_deg_r;

  logic              in_acc;
  logic              wr_en;
  logic [AW-1:0]     raddr;
  logic [TIME_W-1:0] trd;
  logic [VW-1:0]     vrd;
  logic [CW-1:0]     n_c;
  logic              hit;
  logic              last;
  logic              out_free;
  logic [VAL_W:0]    num_s;
  logic [VAL_W:0]    den_s;
  logic              lerp_start;
  lerp_req_t         lerp_req;
  logic              lerp_done;
  logic [VAL_W-1:0]  lerp_res;

  // Clamp the sample count to the table
  always_comb begin
    if (32'(sample_count_r) < 32'd2) begin
      n_c = CW'(2);
    end else if (32'(sample_count_r) > 32'(MAX_SAMPLES)) begin
      n_c = CW'(MAX_SAMPLES);
    end else begin
      n_c = CW'(sample_count_r);
    end
  end

  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (in_kind == KIND_WRITE) && (32'(in_index) < 32'(MAX_SAMPLES));
  assign hit      = pend_r && (trd > t_r);
  assign last     = pend_r && (CW'(pidx_r) == n_r - 1'b1);
  assign out_free = !out_valid_r || !out_stall;
  assign num_s    = {2'b00, t_r} - {2'b00, tlo_r};
  assign den_s    = {2'b00, trd} - {2'b00, tlo_r};

  tti_ram #(.W(TIME_W), .D(MAX_SAMPLES)) u_time_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(in_index)),
    .wdata (in_sample_time),
    .raddr (raddr),
    .rdata (trd)
  );

  tti_ram #(.W(VW), .D(MAX_SAMPLES)) u_val_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(in_index)),
    .wdata ({in_sample_turn_rate, in_sample_speed, in_sample_heading, in_sample_y,
             in_sample_x}),
    .raddr (raddr),
    .rdata (vrd)
  );

  tti_lerp u_lerp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lerp_start),
    .req    (lerp_req),
    .done   (lerp_done),
    .result (lerp_res)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_kind == KIND_QUERY)) begin
          if (in_query_time >= end_time_r || in_query_time == '0) begin
            state_nxt = S_RD_LO;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN:   if (hit || last) state_nxt = S_RD_LO;
      S_RD_LO:  state_nxt = S_RD_HI;
      S_RD_HI:  state_nxt = S_GOT;
      S_GOT:    state_nxt = (direct_r || trd == tlo_r) ? S_EMIT : S_LSTART;
      S_LSTART: state_nxt = S_LWAIT;
      S_LWAIT: begin
        if (lerp_done) begin
          state_nxt = (32'(lane_r) == NUM_LANES - 1) ? S_EMIT : S_LSTART;
        end
      end
      S_EMIT:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall   = (state_r != S_IDLE);
    lerp_start = (state_r == S_LSTART);
    raddr      = lo_r;
    unique case (state_r)
      S_SCAN:  raddr = i_r[AW-1:0];
      S_RD_HI: raddr = hi_r;
      default: raddr = lo_r;
    endcase
    lerp_req.lo      = vlo_r[lane_r];
    lerp_req.hi      = vhi_r[lane_r];
    lerp_req.num_mag = num_mag_r;
    lerp_req.num_neg = num_neg_r;
    lerp_req.den_mag = den_mag_r;
    lerp_req.den_neg = den_neg_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sample_count_r <= CNT_W'(2);
      end_time_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[CNT_W-1:0];
          REG_END_TIME:     end_time_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        t_r    <= in_query_time;
        n_r    <= n_c;
        i_r    <= '0;
        pend_r <= 1'b0;
        direct_r <= 1'b1;
        deg_r    <= 1'b0;
        if (in_query_time >= end_time_r) begin
          lo_r <= AW'(n_c - 1'b1);
        end else begin
          lo_r <= '0;
        end
      end
      S_SCAN: begin
        // issue the next time read while checking the previous one
        if (i_r < n_r) begin
          i_r    <= i_r + 1'b1;
          pend_r <= 1'b1;
          pidx_r <= i_r[AW-1:0];
        end else begin
          pend_r <= 1'b0;
        end
        if (hit) begin
          if (pidx_r == '0) begin
            lo_r <= '0;
          end else begin
            lo_r     <= pidx_r - 1'b1;
            hi_r     <= pidx_r;
            direct_r <= 1'b0;
          end
        end else if (last) begin
          lo_r     <= AW'(n_r - CW'(2));
          hi_r     <= AW'(n_r - 1'b1);
          direct_r <= 1'b0;
        end
      end
      S_RD_HI: begin
        tlo_r <= trd;
        vlo_r <= vrd;
      end
      S_GOT: begin
        vhi_r     <= vrd;
        res_r     <= vlo_r;
        deg_r     <= !direct_r && (trd == tlo_r);
        num_neg_r <= num_s[VAL_W];
        num_mag_r <= num_s[VAL_W] ? TIME_W'(-num_s) : num_s[TIME_W-1:0];
        den_neg_r <= den_s[VAL_W];
        den_mag_r <= den_s[VAL_W] ? TIME_W'(-den_s) : den_s[TIME_W-1:0];
        lane_r    <= '0;
      end
      S_LWAIT: begin
        if (lerp_done) begin
          res_r[lane_r] <= lerp_res;
          lane_r        <= lane_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_time_r <= t_r;
          out_vals_r <= res_r;
          out_deg_r  <= deg_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_time       = out_time_r;
  assign out_x          = out_vals_r[0];
  assign out_y          = out_vals_r[1];
  assign out_heading    = out_vals_r[2];
  assign out_speed      = out_vals_r[3];
  assign out_turn_rate  = out_vals_r[4];
  assign out_degenerate = out_deg_r;

  // A query always leaves idle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == KIND_QUERY) |=> (state_r != S_IDLE))
    else $error("query accepted without leaving idle");

  // The scan never runs past the sample count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (i_r <= n_r))
    else $error("scan index beyond sample count");

  // The divider finishes only for a lane in flight
  a_lerp_owner: assert property (@(posedge clk) disable iff (!rst_n)
    lerp_done |-> (state_r == S_LWAIT))
    else $error("interpolation lane finished outside wait state");

  // A result lands in the output register only from the emit state
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result raised outside emit");

endmodule

// File: tb/tb.sv
// Self-checking testbench for trajectory_time_interpolator: table loads and time queries.
// Depends on tti_pkg and the block RTL; a built-in predictor tracks the sample table.
`timescale 1ns / 1ps

module tb;
  import tti_pkg::*;

  localparam int  DEPTH     = 1024;
  localparam int  CYC_LIMIT = 4000000;
  localparam logic [TIME_W-1:0] T_MAX = 31'h7FFFFFFF;

  typedef struct packed {
    logic                        kind;
    logic [9:0]                  index;
    logic [TIME_W-1:0]           stime;
    logic [4:0][VAL_W-1:0]       vals;
    logic [TIME_W-1:0]           qtime;
  } beat_t;

  typedef struct packed {
    logic [TIME_W-1:0]     t;
    logic [4:0][VAL_W-1:0] v;
    logic                  deg;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_SAMPLE_COUNT;
  logic [TIME_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = KIND_WRITE;
  logic [9:0] in_index = '0;
  logic [TIME_W-1:0] in_sample_time = '0;
  logic [VAL_W-1:0] in_sample_x = '0, in_sample_y = '0, in_sample_heading = '0;
  logic [VAL_W-1:0] in_sample_speed = '0, in_sample_turn_rate = '0;
  logic [TIME_W-1:0] in_query_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TIME_W-1:0] out_time;
  logic [VAL_W-1:0] out_x, out_y, out_heading, out_speed, out_turn_rate;
  logic out_degenerate;

  trajectory_time_interpolator u_dut (.*);

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  logic [TIME_W-1:0]     tab_time [DEPTH];
  logic [4:0][VAL_W-1:0] tab_val  [DEPTH];
  logic [10:0]           mdl_count = 11'd2;
  logic [TIME_W-1:0]     mdl_end = '0;

  beat_t pending [$];
  pose_t poses_due [$];
  int    errors = 0;
  bit    calm = 1'b0;

  function automatic pose_t sample_at(int k, logic [TIME_W-1:0] t, logic d);
    pose_t p;
    p.t = t;
    p.v = tab_val[k];
    p.deg = d;
    return p;
  endfunction

  function automatic logic [VAL_W-1:0] blend(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                             longint num, longint den);
    longint lo, q, r;
    lo = longint'($signed(a));
    q = ((longint'($signed(b)) - lo) * num) / den;
    if (q > 64'sd8589934592) q = 64'sd8589934592;
    if (q < -64'sd8589934592) q = -64'sd8589934592;
    r = lo + q;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[VAL_W-1:0];
  endfunction

  // Apply one accepted beat: a write updates the table, a query queues the pose it produces
  function automatic void predict_pose(beat_t b);
    int n, lo, hi, i;
    bit found;
    longint num, den;
    pose_t p;
    logic [TIME_W-1:0] t;
    if (b.kind == KIND_WRITE) begin
      tab_time[b.index] = b.stime;
      tab_val[b.index] = b.vals;
      return;
    end
    n = mdl_count;
    if (n < 2) n = 2;
    if (n > DEPTH) n = DEPTH;
    t = b.qtime;
    found = 1'b0;
    if (t >= mdl_end) begin
      poses_due.insert(poses_due.size(), sample_at(n - 1, t, 1'b0));
      return;
    end
    if (t == 0) begin
      poses_due.insert(poses_due.size(), sample_at(0, t, 1'b0));
      return;
    end
    lo = n - 2;
    hi = n - 1;
    for (i = 0; i < n; i++) begin
      if (tab_time[i] > t) begin
        found = 1'b1;
        break;
      end
    end
    if (found) begin
      if (i == 0) begin
        poses_due.insert(poses_due.size(), sample_at(0, t, 1'b0));
        return;
      end
      lo = i - 1;
      hi = i;
    end
    if (tab_time[hi] == tab_time[lo]) begin
      poses_due.insert(poses_due.size(), sample_at(lo, t, 1'b1));
      return;
    end
    num = longint'(t) - longint'(tab_time[lo]);
    den = longint'(tab_time[hi]) - longint'(tab_time[lo]);
    p.t = t;
    p.deg = 1'b0;
    for (int f = 0; f < 5; f++) p.v[f] = blend(tab_val[lo][f], tab_val[hi][f], num, den);
    poses_due.insert(poses_due.size(), p);
  endfunction

  // Input driver: pop the next beat after a random gap, hold it while stalled
  int    gap_left = 0;
  beat_t cur;
  always @(posedge clk) begin
    bit fire, nv;
    fire = in_valid && !in_stall;
    nv = in_valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (fire) predict_pose(cur);
      if (!in_valid || fire) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          in_kind <= cur.kind;
          in_index <= cur.index;
          in_sample_time <= cur.stime;
          in_sample_x <= cur.vals[0];
          in_sample_y <= cur.vals[1];
          in_sample_heading <= cur.vals[2];
          in_sample_speed <= cur.vals[3];
          in_sample_turn_rate <= cur.vals[4];
          in_query_time <= cur.qtime;
          nv = 1'b1;
          gap_left = calm ? 0 : $urandom_range(0, 3);
        end
      end
    end
    in_valid <= nv;
  end

  // Result monitor: random stall, compare each accepted pose with the oldest due
  int stall_left = 0;
  always @(posedge clk) begin
    pose_t got, want;
    logic [6:0][31:0] gf, wf;
    if (rst_n && out_valid && !out_stall) begin
      got.t = out_time;
      got.v = {out_turn_rate, out_speed, out_heading, out_y, out_x};
      got.deg = out_degenerate;
      if (poses_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pose at t=%h", out_time);
      end else begin
        want = poses_due.pop_front();
        gf = {32'(got.deg), got.v, 1'b0, got.t};
        wf = {32'(want.deg), want.v, 1'b0, want.t};
        for (int f = 0; f < 7; f++) begin
          if (gf[f] !== wf[f]) begin
            errors++;
            if (errors <= 10)
              $display("mismatch field %0d query t=%h: expected %h got %h",
                       f, want.t, wf[f], gf[f]);
          end
        end
      end
      stall_left = calm ? 0 : $urandom_range(0, 3);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_write(int idx, logic [TIME_W-1:0] t, logic [4:0][VAL_W-1:0] v);
    beat_t b;
    b = '0;
    b.kind = KIND_WRITE;
    b.index = idx[9:0];
    b.stime = t;
    b.vals = v;
    b.qtime = TIME_W'($urandom());
    pending.insert(pending.size(), b);
  endtask

  task automatic push_query(logic [TIME_W-1:0] t);
    beat_t b;
    b.kind = KIND_QUERY;
    b.index = 10'($urandom());
    b.stime = TIME_W'($urandom());
    for (int f = 0; f < 5; f++) b.vals[f] = $urandom();
    b.qtime = t;
    pending.insert(pending.size(), b);
  endtask

  // Wait until every beat is in and every pose is out, then let the block settle
  task automatic drain();
    do @(posedge clk); while (pending.size() != 0 || in_valid || poses_due.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [TIME_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_SAMPLE_COUNT) mdl_count = data[10:0];
    else mdl_end = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 20)) - 10) <<< 16;
      default: return $urandom();
    endcase
  endfunction

  // One phase: pick and write registers, load a well-formed table, then mixed traffic
  task automatic run_phase(int count, int nq);
    logic [TIME_W-1:0] tt [DEPTH];
    logic [4:0][VAL_W-1:0] v;
    logic [TIME_W-1:0] t, endt, span_hi;
    int eff, stepmax;
    eff = count < 2 ? 2 : (count > DEPTH ? DEPTH : count);
    stepmax = eff > 64 ? 32'h1F000 : 32'h400000;
    t = $urandom_range(0, 3) == 0 ? 31'd0 : 31'($urandom_range(1, 32'h100000));
    for (int k = 0; k < eff; k++) begin
      tt[k] = t;
      if ($urandom_range(0, 7) != 0) t = t + 31'($urandom_range(1, stepmax));
    end
    span_hi = tt[eff - 1] + 31'h10000;
    case ($urandom_range(0, 3))
      0: endt = T_MAX;
      1: endt = '0;
      2: endt = tt[$urandom_range(0, eff - 1)];
      default: endt = 31'($urandom_range(tt[0], span_hi));
    endcase
    drain();
    calm = ($urandom_range(0, 4) == 0);
    cfg_write(REG_SAMPLE_COUNT, 31'(count));
    cfg_write(REG_END_TIME, endt);
    for (int k = 0; k < eff; k++) begin
      for (int f = 0; f < 5; f++) v[f] = rand_val();
      push_write(k, tt[k], v);
    end
    for (int q = 0; q < nq; q++) begin
      case ($urandom_range(0, 11))
        0: begin
          // stray write anywhere in the table
          for (int f = 0; f < 5; f++) v[f] = rand_val();
          push_write($urandom_range(0, DEPTH - 1), TIME_W'($urandom()), v);
        end
        1: push_query('0);
        2: push_query(TIME_W'($urandom()));
        3: push_query(endt == T_MAX ? T_MAX : 31'($urandom_range(endt, T_MAX)));
        default: push_query(31'($urandom_range(tt[0] == 0 ? 0 : tt[0] - 1, span_hi)));
      endcase
    end
  endtask

  initial begin
    logic [4:0][VAL_W-1:0] v;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset registers, end test before zero test
    push_write(0, 31'h10000, {32'h1, 32'hFFFFFFFF, 32'h0, 32'h80000000, 32'h7FFFFFFF});
    push_write(1, 31'h20000, {32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000});
    push_query('0);
    push_query(T_MAX);
    drain();
    cfg_write(REG_SAMPLE_COUNT, 31'd3);
    cfg_write(REG_END_TIME, T_MAX);
    push_write(2, 31'h20000, {5{32'h12345678}});
    push_query('0);                // zero time
    push_query(31'h8000);          // before first sample
    push_query(31'h18000);         // full-scale interpolation
    push_query(31'h20000);         // equal bracketing times
    push_query(31'h7FFFFFFE);      // degenerate tail
    push_write(1023, T_MAX, {5{32'hFFFFFFFF}});
    push_write(2, 31'h30000, {32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h5});
    push_query(31'h7FFFFFFE);      // extrapolate and saturate
    push_query(31'h28000);
    drain();
    cfg_write(REG_END_TIME, 31'h20000);
    push_query(31'h20000);         // exactly at end
    push_query(31'h1FFFF);

    // Random phases over small tables; counts below two are clamped
    run_phase(0, 12);
    run_phase(1, 12);
    for (int p = 0; p < 20; p++) run_phase($urandom_range(2, 16), 14);
    run_phase(2, 12);

    drain();
    repeat (400) @(posedge clk);
    if (errors == 0 && poses_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
